>>> sv/sorted_top_k_insert_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted top-k insert block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TOP_K_INSERT_ASSERT_SVH
`define SORTED_TOP_K_INSERT_ASSERT_SVH

// Same-cycle implication under reset.
`define STK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stk check failed");

// Implication checked a fixed number of cycles later.
`define STK_ASSERT_LATER(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("stk check failed");

`endif

>>> sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Types, codes and the ranking compare shared by the sorted top-k insert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

  localparam int unsigned NamePartW = 40;
  localparam int unsigned NameParts = 4;
  localparam int unsigned NameW     = NamePartW * NameParts;
  localparam int unsigned NameMaxCh = NameW / 8;

  localparam logic [4:0] PLACED_NONE = 5'h1F;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_e;

  typedef struct packed {
    logic [31:0]      points;
    logic [31:0]      ratio;
    logic [31:0]      play_time;
    logic [31:0]      date;
    logic [NameW-1:0] name;
  } rec_t;

  // Link between neighbouring cells.
  typedef struct packed {
    logic take;
    logic valid;
    rec_t rec;
  } link_t;

  // True when record a strictly outranks record b.
  function automatic logic outranks(rec_t a, rec_t b);
    logic res;
    if (a.points != b.points) begin
      res = a.points > b.points;
    end else if (a.ratio != b.ratio) begin
      res = a.ratio > b.ratio;
    end else if (a.play_time != b.play_time) begin
      res = a.play_time < b.play_time;
    end else if (a.date != b.date) begin
      res = a.date < b.date;
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/stk_cell.sv
// ----------------------------------------------------------------------------
// stk_cell
// One table slot: compares the broadcast record with its own entry and
// either holds, takes the new record or takes its upper neighbour's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stk_cell #(
  parameter int unsigned NAME_BITS = 160
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ins_en_i,
  input  wire stk_pkg::rec_t  new_rec_i,
  input  wire stk_pkg::link_t prev_i,
  output stk_pkg::link_t     link_o,
  output logic               placed_o
);
  import stk_pkg::*;

  logic                 valid_q, valid_d;
  logic [31:0]          points_q, ratio_q, time_q, date_q;
  logic [NAME_BITS-1:0] name_q;
  rec_t                 mine;
  rec_t                 load_rec;
  logic                 take;
  logic                 load_new;
  logic                 shift;

  always_comb begin
    mine           = '0;
    mine.points    = points_q;
    mine.ratio     = ratio_q;
    mine.play_time = time_q;
    mine.date      = date_q;
    mine.name      = NameW'(name_q);
  end

  // Slot at or below the insertion point; monotonic along the row.
  assign take     = !valid_q || outranks(new_rec_i, mine);
  assign load_new = ins_en_i && take && !prev_i.take;
  assign shift    = ins_en_i && prev_i.take;
  assign load_rec = shift ? prev_i.rec : new_rec_i;

  always_comb begin
    valid_d = valid_q;
    if (shift) begin
      valid_d = prev_i.valid;
    end else if (load_new) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift || load_new) begin
      points_q <= load_rec.points;
      ratio_q  <= load_rec.ratio;
      time_q   <= load_rec.play_time;
      date_q   <= load_rec.date;
      name_q   <= load_rec.name[NAME_BITS-1:0];
    end
  end

  assign link_o.take  = take;
  assign link_o.valid = valid_q;
  assign link_o.rec   = mine;
  assign placed_o     = load_new;

endmodule

`default_nettype wire

>>> sv/sorted_top_k_insert.sv
// ----------------------------------------------------------------------------
// sorted_top_k_insert
// Ranked table of up to TABLE_DEPTH records held in a row of compare/shift
// cells; inserts in rank order and reads back one slot per request.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                    Payload
// request   in   start && !busy               req_type_i, read_slot_i, new_*_i
// result    out  result_valid_o (one cycle)   placed_slot_o, entry_count_o,
//                                             entry_valid_o, out_*_o
//
// Each request first registers the beat; then every cell compares against
// the broadcast record and the row shifts in place.
// busy is high for the cycle after acceptance; the result strobe follows it.
// The result register frees the row, so the next request may be accepted
// in the cycle the strobe is shown. Reset empties the table (valid flags
// only). The receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_top_k_insert #(
  parameter int unsigned TABLE_DEPTH = 10,
  parameter int unsigned NAME_CHARS  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [3:0]  read_slot_i,
  input  wire logic [31:0] new_points_i,
  input  wire logic [31:0] new_ratio_i,
  input  wire logic [31:0] new_play_time_i,
  input  wire logic [31:0] new_date_i,
  input  wire logic [39:0] new_name_part0_i,
  input  wire logic [39:0] new_name_part1_i,
  input  wire logic [39:0] new_name_part2_i,
  input  wire logic [39:0] new_name_part3_i,
  output logic             result_valid_o,
  output logic [4:0]       placed_slot_o,
  output logic [3:0]       entry_count_o,
  output logic             entry_valid_o,
  output logic [31:0]      out_points_o,
  output logic [31:0]      out_ratio_o,
  output logic [31:0]      out_play_time_o,
  output logic [31:0]      out_date_o,
  output logic [39:0]      out_name_part0_o,
  output logic [39:0]      out_name_part1_o,
  output logic [39:0]      out_name_part2_o,
  output logic [39:0]      out_name_part3_o
);
  import stk_pkg::*;

  localparam int unsigned StoredChars = (NAME_CHARS < NameMaxCh) ? NAME_CHARS : NameMaxCh;
  localparam int unsigned NameBits    = StoredChars * 8;
  localparam int unsigned CntW        = $clog2(TABLE_DEPTH + 1);

  logic             busy_q;
  req_e             type_q;
  logic [3:0]       slot_q;
  rec_t             rec_q;
  logic [CntW-1:0]  count_q, count_d;

  logic             res_valid_q;
  logic [4:0]       placed_q, placed_d;
  logic [3:0]       cnt_out_q;
  logic             hit_q, hit_d;
  rec_t             out_q, out_d;

  logic             ins_en;
  link_t            links [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] placed;
  logic [7:0]       cnt8;

  wire accept = start && !busy_q;

  assign busy   = busy_q;
  assign ins_en = busy_q && (type_q == REQ_INSERT);

  // Latch the request beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q          <= req_e'(req_type_i);
      slot_q          <= read_slot_i;
      rec_q.points    <= new_points_i;
      rec_q.ratio     <= new_ratio_i;
      rec_q.play_time <= new_play_time_i;
      rec_q.date      <= new_date_i;
      rec_q.name      <= {new_name_part3_i, new_name_part2_i,
                          new_name_part1_i, new_name_part0_i};
    end
  end

  // Row of cells, slot 0 at the head.
  assign links[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    stk_cell #(
      .NAME_BITS (NameBits)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_en_i  (ins_en),
      .new_rec_i (rec_q),
      .prev_i    (links[g]),
      .link_o    (links[g+1]),
      .placed_o  (placed[g])
    );
  end

  // Slot taken, entry count and read-back.
  always_comb begin
    placed_d = PLACED_NONE;
    count_d  = count_q;
    hit_d    = 1'b0;
    out_d    = '0;
    if (ins_en && (|placed)) begin
      placed_d = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (placed[i]) begin
          placed_d = placed_d | 5'(i);
        end
      end
      if (count_q < CntW'(TABLE_DEPTH)) begin
        count_d = count_q + 1'b1;
      end
    end
    if (busy_q && (type_q == REQ_READ)) begin
      hit_d = 8'(slot_q) < 8'(count_q);
      if (hit_d) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (8'(slot_q) == 8'(i)) begin
            out_d = out_d | links[i+1].rec;
          end
        end
      end
    end
  end

  assign cnt8 = 8'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      placed_q  <= placed_d;
      cnt_out_q <= cnt8[3:0];
      hit_q     <= hit_d;
      out_q     <= out_d;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign placed_slot_o    = placed_q;
  assign entry_count_o    = cnt_out_q;
  assign entry_valid_o    = hit_q;
  assign out_points_o     = out_q.points;
  assign out_ratio_o      = out_q.ratio;
  assign out_play_time_o  = out_q.play_time;
  assign out_date_o       = out_q.date;
  assign out_name_part0_o = out_q.name[39:0];
  assign out_name_part1_o = out_q.name[79:40];
  assign out_name_part2_o = out_q.name[119:80];
  assign out_name_part3_o = out_q.name[159:120];

endmodule

`default_nettype wire

>>> sv/stk_checker.sv
// ----------------------------------------------------------------------------
// stk_checker
// Port-level checks on timing and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_top_k_insert_assert.svh"

module stk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic [4:0]  placed_slot_o,
  input wire logic [3:0]  entry_count_o,
  input wire logic        entry_valid_o,
  input wire logic [31:0] out_points_o
);
  import stk_pkg::*;

  wire accept = start && !busy;

  // Every accepted beat gives its result strobe after its busy cycle.
  `STK_ASSERT_LATER(a_result_follows, clk_i, rst_ni, accept, 2, result_valid_o)
  // A request in flight always leads to a result strobe.
  `STK_ASSERT_LATER(a_busy_then_result, clk_i, rst_ni, busy, 1, result_valid_o)
  // A read hit never reports a placement.
  `STK_ASSERT_NOW(a_read_not_placed, clk_i, rst_ni, result_valid_o && entry_valid_o,
                  placed_slot_o == PLACED_NONE)
  // A placed record leaves the table non-empty.
  `STK_ASSERT_NOW(a_placed_nonempty, clk_i, rst_ni,
                  result_valid_o && (placed_slot_o != PLACED_NONE), entry_count_o != 4'd0)
  // A miss returns zero fields.
  `STK_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, result_valid_o && !entry_valid_o,
                  out_points_o == 32'd0)

endmodule

bind sorted_top_k_insert stk_checker u_stk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .placed_slot_o  (placed_slot_o),
  .entry_count_o  (entry_count_o),
  .entry_valid_o  (entry_valid_o),
  .out_points_o   (out_points_o)
);

`default_nettype wire

>>> bench/tb_sorted_top_k_insert.sv
// ----------------------------------------------------------------------------
// tb_sorted_top_k_insert
// Self-checking bench for the ranked top-k table: inserts and reads are
// driven through the start/busy handshake and every result strobe is
// compared field by field against a local ranking-table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_top_k_insert;
  import stk_pkg::*;

  localparam int unsigned TABLE_DEPTH = 10;
  localparam int unsigned NAME_CHARS  = 20;
  localparam int unsigned ITEMS_PER_PHASE = 212;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam logic [NameW-1:0] NAME_KEEP = (NameW'(1) << (8 * NAME_CHARS)) - NameW'(1);

  typedef struct {
    req_e        kind;
    logic [3:0]  slot;
    rec_t        rec;
    logic        near;      // take ranking fields from a stored entry when issued
    logic        drain;     // hold until every outstanding result is back
    int unsigned idle_pct;
  } request_t;

  typedef struct packed {
    logic [4:0] placed;
    logic [3:0] count;
    logic       valid;
    rec_t       rec;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = REQ_INSERT;
  logic [3:0]  read_slot_i = '0;
  logic [31:0] new_points_i = '0;
  logic [31:0] new_ratio_i = '0;
  logic [31:0] new_play_time_i = '0;
  logic [31:0] new_date_i = '0;
  logic [39:0] new_name_part0_i = '0;
  logic [39:0] new_name_part1_i = '0;
  logic [39:0] new_name_part2_i = '0;
  logic [39:0] new_name_part3_i = '0;
  logic        result_valid_o;
  logic [4:0]  placed_slot_o;
  logic [3:0]  entry_count_o;
  logic        entry_valid_o;
  logic [31:0] out_points_o;
  logic [31:0] out_ratio_o;
  logic [31:0] out_play_time_o;
  logic [31:0] out_date_o;
  logic [39:0] out_name_part0_o;
  logic [39:0] out_name_part1_o;
  logic [39:0] out_name_part2_o;
  logic [39:0] out_name_part3_o;

  request_t    request_q[$];
  outcome_t    outcome_q[$];
  request_t    cur_req;
  rec_t        ranked [TABLE_DEPTH];
  int unsigned ranked_count = 0;
  int unsigned fault_count = 0;
  int unsigned stall_cycles = 0;

  sorted_top_k_insert #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .read_slot_i     (read_slot_i),
    .new_points_i    (new_points_i),
    .new_ratio_i     (new_ratio_i),
    .new_play_time_i (new_play_time_i),
    .new_date_i      (new_date_i),
    .new_name_part0_i(new_name_part0_i),
    .new_name_part1_i(new_name_part1_i),
    .new_name_part2_i(new_name_part2_i),
    .new_name_part3_i(new_name_part3_i),
    .result_valid_o  (result_valid_o),
    .placed_slot_o   (placed_slot_o),
    .entry_count_o   (entry_count_o),
    .entry_valid_o   (entry_valid_o),
    .out_points_o    (out_points_o),
    .out_ratio_o     (out_ratio_o),
    .out_play_time_o (out_play_time_o),
    .out_date_o      (out_date_o),
    .out_name_part0_o(out_name_part0_o),
    .out_name_part1_o(out_name_part1_o),
    .out_name_part2_o(out_name_part2_o),
    .out_name_part3_o(out_name_part3_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Lower play time and date rank higher, so invert them into one sort key.
  function automatic logic ranks_above(rec_t a, rec_t b);
    return {a.points, a.ratio, ~a.play_time, ~a.date} >
           {b.points, b.ratio, ~b.play_time, ~b.date};
  endfunction

  task automatic apply_request(input request_t rq, output outcome_t res);
    int unsigned pos;
    int unsigned last;
    logic        found;
    rec_t        fresh;
    res        = '0;
    res.placed = PLACED_NONE;
    if (rq.kind == REQ_INSERT) begin
      fresh      = rq.rec;
      fresh.name = fresh.name & NAME_KEEP;
      pos        = ranked_count;
      found      = 1'b0;
      for (int i = 0; i < ranked_count; i++) begin
        if (!found && ranks_above(fresh, ranked[i])) begin
          pos   = i;
          found = 1'b1;
        end
      end
      if (found || ranked_count < TABLE_DEPTH) begin
        last = (ranked_count < TABLE_DEPTH) ? ranked_count : TABLE_DEPTH - 1;
        for (int k = last; k > pos; k--) ranked[k] = ranked[k-1];
        ranked[pos] = fresh;
        if (ranked_count < TABLE_DEPTH) ranked_count++;
        res.placed = pos[4:0];
      end
    end else if (rq.slot < ranked_count) begin
      res.valid = 1'b1;
      res.rec   = ranked[rq.slot];
    end
    res.count = ranked_count[3:0];
  endtask

  function automatic logic [NameW-1:0] random_name();
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] edge_value();
    logic [31:0] v;
    case ($urandom_range(2))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic request_t insert_req(logic [31:0] pts, logic [31:0] rat,
                                          logic [31:0] tim, logic [31:0] dat);
    request_t rq;
    rq.kind          = REQ_INSERT;
    rq.slot          = 4'($urandom_range(15));
    rq.rec.points    = pts;
    rq.rec.ratio     = rat;
    rq.rec.play_time = tim;
    rq.rec.date      = dat;
    rq.rec.name      = random_name();
    rq.near          = 1'b0;
    rq.drain         = 1'b0;
    rq.idle_pct      = 0;
    return rq;
  endfunction

  function automatic request_t read_req(logic [3:0] slot);
    request_t rq;
    rq      = insert_req($urandom(), $urandom(), $urandom(), $urandom());
    rq.kind = REQ_READ;
    rq.slot = slot;
    return rq;
  endfunction

  // Copy the ranking of a stored entry and nudge one field, or leave a full tie.
  function automatic request_t near_variant(request_t rq);
    int unsigned pick;
    if (ranked_count == 0) return rq;
    pick             = $urandom_range(ranked_count - 1);
    rq.rec.points    = ranked[pick].points;
    rq.rec.ratio     = ranked[pick].ratio;
    rq.rec.play_time = ranked[pick].play_time;
    rq.rec.date      = ranked[pick].date;
    case ($urandom_range(8))
      0:       rq.rec.points    = rq.rec.points + 1;
      1:       rq.rec.points    = rq.rec.points - 1;
      2:       rq.rec.ratio     = rq.rec.ratio + 1;
      3:       rq.rec.ratio     = rq.rec.ratio - 1;
      4:       rq.rec.play_time = rq.rec.play_time + 1;
      5:       rq.rec.play_time = rq.rec.play_time - 1;
      6:       rq.rec.date      = rq.rec.date + 1;
      7:       rq.rec.date      = rq.rec.date - 1;
      default: ;
    endcase
    return rq;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want)
      note_fault($sformatf("%s mismatch: expected %h, got %h", what, want, got));
  endtask

  // Driver: move a beat onto the ports whenever the last one was taken.
  always @(posedge clk_i) begin : driver
    outcome_t res;
    request_t nxt;
    logic     taken;
    logic     go;
    if (rst_ni) begin
      taken = start && !busy;
      if (taken) begin
        apply_request(cur_req, res);
        outcome_q.push_back(res);
      end
      if (!start || taken) begin
        go = 1'b0;
        if (request_q.size() != 0) begin
          nxt = request_q[0];
          go  = !(nxt.drain && outcome_q.size() != 0) &&
                ($urandom_range(99) >= nxt.idle_pct);
        end
        if (go) begin
          nxt = request_q.pop_front();
          if (nxt.near) nxt = near_variant(nxt);
          cur_req          <= nxt;
          req_type_i       <= nxt.kind;
          read_slot_i      <= nxt.slot;
          new_points_i     <= nxt.rec.points;
          new_ratio_i      <= nxt.rec.ratio;
          new_play_time_i  <= nxt.rec.play_time;
          new_date_i       <= nxt.rec.date;
          new_name_part0_i <= nxt.rec.name[39:0];
          new_name_part1_i <= nxt.rec.name[79:40];
          new_name_part2_i <= nxt.rec.name[119:80];
          new_name_part3_i <= nxt.rec.name[159:120];
        end
        start <= go;
      end
    end
  end

  // Monitor: every strobe retires the oldest expected outcome.
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (outcome_q.size() == 0) begin
        note_fault($sformatf("result beat with nothing expected: placed %h count %h",
                             placed_slot_o, entry_count_o));
      end else begin
        want = outcome_q.pop_front();
        check_field("placed_slot", 64'(want.placed), 64'(placed_slot_o));
        check_field("entry_count", 64'(want.count), 64'(entry_count_o));
        check_field("entry_valid", 64'(want.valid), 64'(entry_valid_o));
        check_field("out_points", 64'(want.rec.points), 64'(out_points_o));
        check_field("out_ratio", 64'(want.rec.ratio), 64'(out_ratio_o));
        check_field("out_play_time", 64'(want.rec.play_time), 64'(out_play_time_o));
        check_field("out_date", 64'(want.rec.date), 64'(out_date_o));
        check_field("out_name_part0", 64'(want.rec.name[39:0]), 64'(out_name_part0_o));
        check_field("out_name_part1", 64'(want.rec.name[79:40]), 64'(out_name_part1_o));
        check_field("out_name_part2", 64'(want.rec.name[119:80]), 64'(out_name_part2_o));
        check_field("out_name_part3", 64'(want.rec.name[159:120]), 64'(out_name_part3_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    request_t    rq;
    int unsigned idle_pct;
    int unsigned roll;

    // Directed: empty reads, each ranking rule, ties, a full table and drops.
    request_q.push_back(read_req(4'd0));
    request_q.push_back(read_req(4'd15));
    request_q.push_back(insert_req(32'd100, 32'd5, 32'd50, 32'd50));
    request_q.push_back(insert_req(32'd100, 32'd5, 32'd50, 32'd50));
    request_q.push_back(insert_req(32'd100, 32'd5, 32'd50, 32'd49));
    request_q.push_back(insert_req(32'd100, 32'd5, 32'd49, 32'd60));
    request_q.push_back(insert_req(32'd100, 32'd6, 32'd90, 32'd90));
    request_q.push_back(insert_req(32'd101, 32'd0, '1, '1));
    rq          = insert_req('1, '1, '0, '0);
    rq.rec.name = '1;
    request_q.push_back(rq);
    rq          = insert_req('0, '0, '1, '1);
    rq.rec.name = '0;
    request_q.push_back(rq);
    request_q.push_back(insert_req('0, '0, '1, '1));
    request_q.push_back(insert_req(32'd1, 32'd0, '1, '1));
    request_q.push_back(read_req(4'd9));
    request_q.push_back(read_req(4'd10));
    request_q.push_back(insert_req('0, '0, '1, '1));
    request_q.push_back(insert_req(32'd100, 32'd5, 32'd50, 32'd50));
    request_q.push_back(read_req(4'd0));
    request_q.push_back(read_req(4'd5));
    request_q.push_back(read_req(4'd9));
    request_q.push_back(read_req(4'd15));

    // Random phases: no idling, heavy sender idling, none again, light idling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 84 : (ph == 3) ? 9 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 35) begin
          rq = read_req(4'($urandom_range(15)));
        end else if (roll < 75) begin
          rq      = insert_req($urandom(), $urandom(), $urandom(), $urandom());
          rq.near = 1'b1;
        end else if (roll < 90) begin
          rq = insert_req($urandom(), $urandom(), $urandom(), $urandom());
        end else begin
          rq = insert_req(edge_value(), edge_value(), edge_value(), edge_value());
          if ($urandom_range(1)) rq.rec.name = $urandom_range(1) ? '1 : '0;
        end
        rq.idle_pct = idle_pct;
        rq.drain    = (n == 0);
        request_q.push_back(rq);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (request_q.size() != 0 || start || outcome_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (outcome_q.size() != 0) note_fault("results still outstanding at end of run");
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/stk_pkg.sv
sv/stk_cell.sv
sv/sorted_top_k_insert.sv
sv/stk_checker.sv
bench/tb_sorted_top_k_insert.sv
